// ===== design/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg: shared definitions for the sliding window min/max/median block
// Holds field widths, the read address selector and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

    // Field widths of one beat
    localparam int DATA_W         = 32;
    localparam int FILL_W         = 7;
    localparam int OUT_TDATA_W    = 104;
    localparam int OUT_PAD_W      = OUT_TDATA_W - 3 * DATA_W - FILL_W;
    localparam int WINDOW_DEFAULT = 64;

    // Address source for the sorted store read port
    typedef enum logic [2:0] {
        RD_MID,
        RD_NEAR,
        RD_FAR,
        RD_FIRST,
        RD_LAST,
        RD_HALF
    } swmm_rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic         accept;
        logic         load_r;
        logic         search_step;
        logic         walk_start;
        logic         walk_step;
        swmm_rd_sel_t rd_sel;
        logic         cap_min;
        logic         cap_max;
        logic         cap_med;
        logic         load_out;
    } swmm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic search_done;
        logic walk_cont;
        logic out_busy;
    } swmm_status_t;

endpackage

`default_nettype wire

// ===== design/sliding_window_min_max_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max_median: min, max and upper median of recent samples
// Keeps the last WINDOW durations in arrival order and in sorted order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per 32-bit unsigned duration. Master channel:
//   one beat per accepted sample with the minimum, maximum and median
//   (sorted element at index floor(count/2)) and the current sample count.
//   Samples are handled one at a time. s_tready is high while no update is
//   in progress. Until the window is full an update is bounded by the shift
//   walk over the sorted store, one entry per cycle through its single read
//   and write port. Once full, the dropped sample is first found by a binary
//   search, each step a read state and a compare state, before the walk.
//   The result beat is loaded into the output register as the controller
//   returns to idle.
//   The result sits in an output register; while the receiver stalls, the
//   next sample is still taken and worked on, and only its final load
//   waits for the master beat to be taken.
//   Reset empties the window and drops any pending result; no memory
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max_median #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] sample_value
    input  wire logic [swmm_pkg::DATA_W-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] window_min, [63:32] window_max, [95:64] window_median,
    // [102:96] fill_count, [103] zero
    output logic [swmm_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    swmm_pkg::swmm_cmd_t    cmd;
    swmm_pkg::swmm_status_t status;

    // Sequencer
    swmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores and result registers
    swmm_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_sample (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/swmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmm_ctrl: sequencer for one window update
// Steps through ring read and binary search for the dropped sample (once full),
// the shift walk over the sorted store, the three result reads and the output load.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire swmm_pkg::swmm_status_t status,
    output swmm_pkg::swmm_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RING,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_PRIME,
        ST_WALK,
        ST_RES_FIRST,
        ST_RES_LAST,
        ST_RES_HALF,
        ST_RES_MED,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new beat only between updates
    assign s_tready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = swmm_pkg::RD_MID;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.full ? ST_RING : ST_PRIME;
                end
            end
            ST_RING: begin
                cmd.load_r = 1'b1;
                state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD: begin
                if (status.search_done) begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_PRIME;
                end else begin
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                cmd.search_step = 1'b1;
                state_next      = ST_SRCH_RD;
            end
            ST_PRIME: begin
                cmd.rd_sel = swmm_pkg::RD_NEAR;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.rd_sel    = swmm_pkg::RD_FAR;
                cmd.walk_step = 1'b1;
                if (!status.walk_cont) begin
                    state_next = ST_RES_FIRST;
                end
            end
            ST_RES_FIRST: begin
                cmd.rd_sel = swmm_pkg::RD_FIRST;
                state_next = ST_RES_LAST;
            end
            ST_RES_LAST: begin
                cmd.rd_sel  = swmm_pkg::RD_LAST;
                cmd.cap_min = 1'b1;
                state_next  = ST_RES_HALF;
            end
            ST_RES_HALF: begin
                cmd.rd_sel  = swmm_pkg::RD_HALF;
                cmd.cap_max = 1'b1;
                state_next  = ST_RES_MED;
            end
            ST_RES_MED: begin
                cmd.cap_med = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/swmm_dpath.sv =====
// ----------------------------------------------------------------------------
// swmm_dpath: sample ring, sorted store and result registers
// Both stores have one write and one registered read port. The sorted
// store is updated by a one-entry-per-cycle shift walk.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_dpath #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [swmm_pkg::DATA_W-1:0]          s_sample,
    input  wire swmm_pkg::swmm_cmd_t                  cmd,
    output swmm_pkg::swmm_status_t                    status,
    input  wire logic                                 m_tready,
    output logic                                      m_tvalid,
    output logic [swmm_pkg::OUT_TDATA_W-1:0]          m_tdata
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW);
    localparam logic [IW:0]   WIN_EXT    = (IW + 1)'(WINDOW);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(WINDOW - 1);

    logic [swmm_pkg::DATA_W-1:0] ring_mem [WINDOW];
    logic [swmm_pkg::DATA_W-1:0] sort_mem [WINDOW];

    logic [swmm_pkg::DATA_W-1:0]      ring_rd_reg;
    logic [swmm_pkg::DATA_W-1:0]      sort_rd_reg;
    logic [CW-1:0]                    count_reg, count_next;
    logic [IW-1:0]                    oldest_reg, oldest_next;
    logic [swmm_pkg::DATA_W-1:0]      v_reg, v_next;
    logic [swmm_pkg::DATA_W-1:0]      r_reg, r_next;
    logic [CW-1:0]                    lo_reg, lo_next;
    logic [CW-1:0]                    hi_reg, hi_next;
    logic [IW-1:0]                    pos_reg, pos_next;
    logic                             dir_reg, dir_next;
    logic [swmm_pkg::DATA_W-1:0]      min_reg, min_next;
    logic [swmm_pkg::DATA_W-1:0]      max_reg, max_next;
    logic [swmm_pkg::DATA_W-1:0]      med_reg, med_next;
    logic [swmm_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                             out_valid_reg, out_valid_next;

    logic          full;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_c;
    logic [IW-1:0] near_addr;
    logic [IW-1:0] far_addr;
    logic [CW-1:0] last_c;
    logic [CW-1:0] half_c;
    logic [IW:0]   fwd_next;
    logic          walk_cont;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] ring_waddr;

    // Address arithmetic
    assign full      = (count_reg == FULL_COUNT);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c     = mid_sum[CW:1];
    assign near_addr = dir_reg ? (pos_reg + IW'(1)) : (pos_reg - IW'(1));
    assign far_addr  = dir_reg ? (pos_reg + IW'(2)) : (pos_reg - IW'(2));
    assign last_c    = count_reg - CW'(1);
    assign half_c    = count_reg >> 1;
    assign fwd_next  = {1'b0, pos_reg} + (IW + 1)'(1);

    // Shift on while the neighbor belongs on the far side of the new sample
    assign walk_cont = dir_reg ? ((fwd_next < WIN_EXT) && (sort_rd_reg < v_reg))
                               : ((pos_reg != '0) && (sort_rd_reg > v_reg));

    assign status.full        = full;
    assign status.search_done = (lo_reg == hi_reg);
    assign status.walk_cont   = walk_cont;
    assign status.out_busy    = out_valid_reg && !m_tready;

    assign ring_waddr = full ? oldest_reg : count_reg[IW-1:0];

    // Select the sorted store read address
    always_comb begin
        unique case (cmd.rd_sel)
            swmm_pkg::RD_MID:   rd_addr = mid_c[IW-1:0];
            swmm_pkg::RD_NEAR:  rd_addr = near_addr;
            swmm_pkg::RD_FAR:   rd_addr = far_addr;
            swmm_pkg::RD_FIRST: rd_addr = '0;
            swmm_pkg::RD_LAST:  rd_addr = last_c[IW-1:0];
            swmm_pkg::RD_HALF:  rd_addr = half_c[IW-1:0];
            default:            rd_addr = '0;
        endcase
    end

    // Write the new sample, read the one it replaces
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ring_mem[ring_waddr] <= s_sample;
            ring_rd_reg          <= ring_mem[oldest_reg];
        end
    end

    // Shift one entry per walk step, read every cycle
    always_ff @(posedge aclk) begin
        if (cmd.walk_step) begin
            sort_mem[pos_reg] <= walk_cont ? sort_rd_reg : v_reg;
        end
        sort_rd_reg <= sort_mem[rd_addr];
    end

    // Next values of the working registers
    always_comb begin
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        v_next         = v_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        med_next       = med_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (cmd.accept) begin
            v_next   = s_sample;
            dir_next = 1'b0;
            pos_next = count_reg[IW-1:0];
            if (full) begin
                oldest_next = (oldest_reg == LAST_SLOT) ? '0 : (oldest_reg + IW'(1));
            end else begin
                count_next = count_reg + CW'(1);
            end
        end

        // Start a lower-bound search for the dropped value
        if (cmd.load_r) begin
            r_next  = ring_rd_reg;
            lo_next = '0;
            hi_next = FULL_COUNT;
        end

        if (cmd.search_step) begin
            if (sort_rd_reg < r_reg) begin
                lo_next = mid_c + CW'(1);
            end else begin
                hi_next = mid_c;
            end
        end

        // Walk toward the new sample's place from the dropped entry
        if (cmd.walk_start) begin
            pos_next = lo_reg[IW-1:0];
            dir_next = (v_reg >= r_reg);
        end

        if (cmd.walk_step && walk_cont) begin
            pos_next = near_addr;
        end

        if (cmd.cap_min) begin
            min_next = sort_rd_reg;
        end
        if (cmd.cap_max) begin
            max_next = sort_rd_reg;
        end
        if (cmd.cap_med) begin
            med_next = sort_rd_reg;
        end

        // Load the output beat, drop it once taken
        if (cmd.load_out) begin
            out_data_next  = {{swmm_pkg::OUT_PAD_W{1'b0}},
                              swmm_pkg::FILL_W'(count_reg), med_reg, max_reg, min_reg};
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        v_reg        <= v_next;
        r_reg        <= r_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pos_reg      <= pos_next;
        dir_reg      <= dir_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        med_reg      <= med_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
